// ===== rtl/random_permutation_shuffle_macros.svh =====
// assertion macros shared by the shuffle modules
`ifndef RANDOM_PERMUTATION_SHUFFLE_MACROS_SVH
`define RANDOM_PERMUTATION_SHUFFLE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define RPS_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/rps_pkg.sv =====
// shared constants, state encoding and control structs of the shuffle block
package rps_pkg;

    localparam int MaxElements = 64;
    localparam int CfgWidth    = 7;
    localparam int RandWidth   = 31;
    localparam int ValueWidth  = 7;
    localparam int PosWidth    = $clog2(MaxElements);
    localparam int CountWidth  = $clog2(MaxElements + 1);
    localparam int BitCntWidth = $clog2(RandWidth);

    localparam logic [CfgWidth-1:0] CountReset = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_READ_I,
        S_READ_J,
        S_WRITE_I,
        S_WRITE_J,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/rps_in_if.sv =====
// input channel carrying one random word per item
interface rps_in_if
    import rps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [RandWidth-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/rps_out_if.sv =====
// output channel carrying one permutation element per item
interface rps_out_if
    import rps_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ValueWidth-1:0] element_value;
    logic [PosWidth-1:0]   position;
    logic                  last_flag;

    modport source (output valid, output element_value, output position,
                    output last_flag, input ready);
    modport sink   (input valid, input element_value, input position,
                    input last_flag, output ready);
endinterface

// ===== rtl/rps_controller.sv =====
// sequencer for accept, divide, swap and output of one shuffle step
`include "random_permutation_shuffle_macros.svh"

module rps_controller
    import rps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = S_READ_I;
                end
            end
            S_READ_I:  n_state = S_READ_J;
            S_READ_J:  n_state = S_WRITE_I;
            S_WRITE_I: n_state = S_WRITE_J;
            S_WRITE_J: n_state = S_FINISH;
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start = i_in_valid;
            end
            S_DIVIDE:  o_cmd.div_step = 1'b1;
            S_READ_I:  o_cmd.rd_i     = 1'b1;
            S_READ_J:  o_cmd.rd_j     = 1'b1;
            S_WRITE_I: o_cmd.wr_i     = 1'b1;
            S_WRITE_J: o_cmd.wr_j     = 1'b1;
            S_FINISH:  o_cmd.load_out = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    `RPS_ASSERT(a_cmd_onehot, $onehot0(o_cmd), "more than one datapath command at once")
    `RPS_ASSERT_NEXT(a_div_exit, (r_state == S_DIVIDE) && i_status.div_last, r_state == S_READ_I, "divide did not hand over to slot read")
    `RPS_ASSERT_NEXT(a_start_div, o_cmd.start, (r_state == S_DIVIDE) && !o_in_ready, "accepted item did not enter divide")

endmodule

// ===== rtl/rps_datapath.sv =====
// slot memory, written marks, remainder unit and output register
`include "random_permutation_shuffle_macros.svh"

module rps_datapath
    import rps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CfgWidth-1:0]  i_cfg_wr_data,
    input  logic [RandWidth-1:0] i_random_word,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    rps_out_if.source            o_out
);

    logic [CfgWidth-1:0]    r_count;
    logic [PosWidth-1:0]    r_pos;
    logic [MaxElements-1:0] r_marks;
    logic                   r_out_valid;

    logic [RandWidth-1:0]   r_dividend;
    logic [PosWidth-1:0]    r_rem;
    logic [BitCntWidth-1:0] r_bit_cnt;
    logic [CountWidth-1:0]  r_span;
    logic                   r_res_last;
    logic [PosWidth-1:0]    r_j;
    logic [ValueWidth-1:0]  r_vi;
    logic [ValueWidth-1:0]  r_vj;
    logic [PosWidth-1:0]    r_res_pos;

    logic [ValueWidth-1:0]  r_slots [MaxElements];
    logic [ValueWidth-1:0]  r_rd_data;
    logic                   r_rd_mark;
    logic [ValueWidth-1:0]  r_rd_ident;

    logic [ValueWidth-1:0]  r_out_value;
    logic [PosWidth-1:0]    r_out_pos;
    logic                   r_out_last;

    logic [CountWidth-1:0]  n_eff;
    logic                   restart;
    logic [PosWidth-1:0]    pos_eff;
    logic [CountWidth:0]    shifted;
    logic                   sub_ok;
    logic [PosWidth-1:0]    raddr;
    logic [PosWidth-1:0]    waddr;
    logic [ValueWidth-1:0]  wdata;
    logic                   we;
    logic [ValueWidth-1:0]  rd_value;

    // effective element count after clamping
    always_comb begin
        priority if (r_count == '0) begin
            n_eff = CountWidth'(1);
        end else if (int'(r_count) > MaxElements) begin
            n_eff = CountWidth'(MaxElements);
        end else begin
            n_eff = CountWidth'(r_count);
        end
    end

    assign restart = ({1'b0, r_pos} >= n_eff);
    assign pos_eff = restart ? '0 : r_pos;

    assign shifted = {(CountWidth - PosWidth)'(0), r_rem, r_dividend[RandWidth-1]};
    assign sub_ok  = (shifted >= {1'b0, r_span});

    assign raddr    = i_cmd.rd_j ? r_j : r_pos;
    assign we       = i_cmd.wr_i | i_cmd.wr_j;
    assign waddr    = i_cmd.wr_i ? r_pos : r_j;
    assign wdata    = i_cmd.wr_i ? rd_value : r_vi;
    assign rd_value = r_rd_mark ? r_rd_data : r_rd_ident;

    assign o_status.div_last = (r_bit_cnt == BitCntWidth'(RandWidth - 1));
    assign o_status.out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CountReset;
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_marks <= '0;
        end else begin
            priority if (i_cmd.start) begin
                if (restart) begin
                    r_pos   <= '0;
                    r_marks <= '0;
                end
            end else if (i_cmd.wr_i) begin
                r_marks[r_pos] <= 1'b1;
            end else if (i_cmd.wr_j) begin
                if (r_res_last) begin
                    r_pos   <= '0;
                    r_marks <= '0;
                end else begin
                    r_pos        <= r_pos + PosWidth'(1);
                    r_marks[r_j] <= 1'b1;
                end
            end
        end
    end

    // remainder by restoring division, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dividend <= i_random_word;
            r_rem      <= '0;
            r_bit_cnt  <= '0;
            r_span     <= n_eff - CountWidth'(pos_eff);
            r_res_last <= (CountWidth'(pos_eff) == (n_eff - CountWidth'(1)));
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[RandWidth-2:0], 1'b0};
            r_bit_cnt  <= r_bit_cnt + BitCntWidth'(1);
            if (sub_ok) begin
                r_rem <= PosWidth'(shifted - {1'b0, r_span});
            end else begin
                r_rem <= PosWidth'(shifted);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slots[waddr] <= wdata;
        end
        r_rd_data  <= r_slots[raddr];
        r_rd_mark  <= r_marks[raddr];
        r_rd_ident <= ValueWidth'({1'b0, raddr} + (PosWidth + 1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_i) begin
            r_j <= r_pos + r_rem;
        end
        if (i_cmd.rd_j) begin
            r_vi <= rd_value;
        end
        if (i_cmd.wr_i) begin
            r_vj      <= rd_value;
            r_res_pos <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_vj;
            r_out_pos   <= r_res_pos;
            r_out_last  <= r_res_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.element_value = r_out_value;
    assign o_out.position      = r_out_pos;
    assign o_out.last_flag     = r_out_last;

    `RPS_ASSERT(a_load_free, i_cmd.load_out |-> (!r_out_valid || o_out.ready), "output overwritten before taken")
    `RPS_ASSERT_NEXT(a_span_nonzero, i_cmd.start, (r_span != '0) && ({1'b0, r_pos} < n_eff), "zero span or position past count")
    `RPS_ASSERT_NEXT(a_round_clear, i_cmd.wr_j && r_res_last, (r_marks == '0) && (r_pos == '0), "round did not clear at last item")

endmodule

// ===== rtl/random_permutation_shuffle.sv =====
// top level of the forward shuffle block
// an item is taken only while idle, so the next waits until the last is through;
// each item runs the 31-step remainder loop and the four slot memory accesses of
// the swap, then waits until the output register is free to take its result.
// reset is synchronous active low: count returns to 64, position and marks clear
module random_permutation_shuffle
    import rps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgWidth-1:0] i_cfg_wr_data,
    rps_in_if.sink              i_in,
    rps_out_if.source           o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    rps_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rps_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_random_word (i_in.random_word),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out         (o_out)
    );

endmodule
